FILE: src/ssh_pkg.sv
// Shared types and constants for the beacon source selector.
// Holds register indexes, verdict codes, field widths and register reset values.
// No dependencies.
package ssh_pkg;

	localparam int ID_W       = 32;
	localparam int STRENGTH_W = 8;
	localparam int TIME_W     = 40;
	localparam int COUNT_W    = 3;
	localparam int MARGIN_W   = 7;
	localparam int HITS_W     = 8;
	localparam int SILENCE_W  = 32;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 5;
	localparam int REG_IDX_W  = 3;

	localparam int ALLOW_ENTRIES_DEFAULT = 4;
	localparam int ALLOW_ENTRIES_MAX     = 4;

	localparam logic [COUNT_W-1:0]   COUNT_RESET   = COUNT_W'(0);
	localparam logic [MARGIN_W-1:0]  MARGIN_RESET  = MARGIN_W'(6);
	localparam logic [HITS_W-1:0]    HITS_RESET    = HITS_W'(3);
	localparam logic [SILENCE_W-1:0] SILENCE_RESET = SILENCE_W'(10000);
	localparam logic [HITS_W-1:0]    HITS_MAX      = {HITS_W{1'b1}};

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ALLOWED_0 = 3'd0,
		REG_ALLOWED_1 = 3'd1,
		REG_ALLOWED_2 = 3'd2,
		REG_ALLOWED_3 = 3'd3,
		REG_COUNT     = 3'd4,
		REG_MARGIN    = 3'd5,
		REG_HITS      = 3'd6,
		REG_SILENCE   = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		VERDICT_KEEP       = 3'd0,
		VERDICT_BIND       = 3'd1,
		VERDICT_SWITCH     = 3'd2,
		VERDICT_NOT_LISTED = 3'd3,
		VERDICT_REFUSED    = 3'd4
	} verdict_t;

endpackage

FILE: src/ssh_if.sv
// Handshake channels of the beacon source selector: beacon in, verdict out.
// Depends on ssh_pkg for field widths and the verdict type.
interface ssh_beacon_if
	import ssh_pkg::*;
();
	logic                         valid;
	logic                         ready;
	logic [ID_W-1:0]              source_id;
	logic signed [STRENGTH_W-1:0] strength;
	logic [TIME_W-1:0]            time_ms;

	modport source (output valid, source_id, strength, time_ms, input ready);
	modport sink (input valid, source_id, strength, time_ms, output ready);
endinterface

interface ssh_result_if
	import ssh_pkg::*;
();
	logic            valid;
	logic            ready;
	verdict_t        verdict;
	logic            accepted;
	logic [ID_W-1:0] shown_id;

	modport source (output valid, verdict, accepted, shown_id, input ready);
	modport sink (input valid, verdict, accepted, shown_id, output ready);
endinterface

FILE: src/source_selector_with_hysteresis_unit.sv
// Top level of the beacon source selector with hysteresis.
// Depends on ssh_pkg and the channel interfaces in ssh_if.sv.
//
// Usage:
//   beacon (sink): one decoded beacon word per handshake: source id, signed
//     strength in dBm, arrival time in ms (non-decreasing).
//   result (source): one word per beacon: verdict, accepted flag and the id
//     bound after that beacon.
//   APB port: allowlist ids, allowlist count, strength margin, hits needed and
//     silence time; write only while no beacon is in flight.
// From beacon acceptance to result valid a word passes one input register and
// one result register. Throughput is one beacon per cycle while the receiver
// takes results; the selection state updates as the word moves into the result
// register, so the next beacon is judged against the updated state.
// Reset clears the binding, the challenger and all control state and loads the
// register reset values. When the receiver stalls, the result register holds
// and the input register fills; beacon.ready drops once both are occupied.
module source_selector_with_hysteresis_unit
	import ssh_pkg::*;
#(
	parameter int ALLOW_ENTRIES = ALLOW_ENTRIES_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	ssh_beacon_if.sink            beacon,
	ssh_result_if.source          result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic [ID_W-1:0]      allowed_q [ALLOW_ENTRIES];
	logic [COUNT_W-1:0]   count_q;
	logic [MARGIN_W-1:0]  margin_q;
	logic [HITS_W-1:0]    hits_needed_q;
	logic [SILENCE_W-1:0] silence_q;

	logic                         bound_q;
	logic [ID_W-1:0]              bound_id_q;
	logic signed [STRENGTH_W-1:0] bound_str_q;
	logic [TIME_W-1:0]            bound_ms_q;
	logic [ID_W-1:0]              rival_id_q;
	logic [HITS_W-1:0]            rival_hits_q;

	logic                         valid_s1;
	logic [ID_W-1:0]              id_s1;
	logic signed [STRENGTH_W-1:0] str_s1;
	logic [TIME_W-1:0]            time_s1;

	logic            out_valid_q;
	verdict_t        out_verdict_q;
	logic            out_accepted_q;
	logic [ID_W-1:0] out_shown_q;

	logic                 cfg_wr;
	reg_idx_t             reg_idx;
	logic                 advance;
	logic                 discovery;
	logic                 listed;
	logic [HITS_W-1:0]    hits_base;
	logic [HITS_W-1:0]    hits_next;
	logic signed [9:0]    thresh;
	logic                 stronger;
	logic [TIME_W:0]      elapsed;
	logic                 silent;
	verdict_t             verdict;
	logic                 take;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_COUNT:   prdata = APB_DATA_W'(count_q);
			REG_MARGIN:  prdata = APB_DATA_W'(margin_q);
			REG_HITS:    prdata = APB_DATA_W'(hits_needed_q);
			REG_SILENCE: prdata = APB_DATA_W'(silence_q);
			default: begin
				for (int i = 0; i < ALLOW_ENTRIES; i++) begin
					if (reg_idx == reg_idx_t'(REG_IDX_W'(i)))
						prdata = APB_DATA_W'(allowed_q[i]);
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ALLOW_ENTRIES; i++)
				allowed_q[i] <= '0;
			count_q       <= COUNT_RESET;
			margin_q      <= MARGIN_RESET;
			hits_needed_q <= HITS_RESET;
			silence_q     <= SILENCE_RESET;
		end else if (cfg_wr) begin
			for (int i = 0; i < ALLOW_ENTRIES; i++) begin
				if (reg_idx == reg_idx_t'(REG_IDX_W'(i)))
					allowed_q[i] <= pwdata[ID_W-1:0];
			end
			unique case (reg_idx)
				REG_COUNT:   count_q       <= pwdata[COUNT_W-1:0];
				REG_MARGIN:  margin_q      <= pwdata[MARGIN_W-1:0];
				REG_HITS:    hits_needed_q <= pwdata[HITS_W-1:0];
				REG_SILENCE: silence_q     <= pwdata[SILENCE_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage handshake: s1 drains whenever the result register is free or taken.
	assign advance      = valid_s1 && (!out_valid_q || result.ready);
	assign beacon.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (beacon.ready) begin
			valid_s1 <= beacon.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (beacon.valid && beacon.ready) begin
			id_s1   <= beacon.source_id;
			str_s1  <= beacon.strength;
			time_s1 <= beacon.time_ms;
		end
	end

	always_comb begin
		discovery = (count_q == '0);
		listed    = 1'b0;
		for (int i = 0; i < ALLOW_ENTRIES; i++) begin
			if ((COUNT_W'(i) < count_q) && (allowed_q[i] == id_s1))
				listed = 1'b1;
		end
		hits_base = (rival_id_q == id_s1) ? rival_hits_q : '0;
		hits_next = (hits_base == HITS_MAX) ? hits_base : hits_base + 1'b1;
		thresh    = 10'(bound_str_q) + $signed({3'b000, margin_q});
		stronger  = 10'(str_s1) > thresh;
		elapsed   = {1'b0, time_s1} - {1'b0, bound_ms_q};
		silent    = !elapsed[TIME_W] &&
			(elapsed[TIME_W-1:0] >= TIME_W'(silence_q));
		priority if (!discovery && !listed)
			verdict = VERDICT_NOT_LISTED;
		else if (!bound_q)
			verdict = VERDICT_BIND;
		else if (id_s1 == bound_id_q)
			verdict = VERDICT_KEEP;
		else if (discovery)
			verdict = stronger ? VERDICT_SWITCH : VERDICT_REFUSED;
		else
			verdict = (hits_next >= hits_needed_q && silent) ?
				VERDICT_SWITCH : VERDICT_REFUSED;
		take = (verdict == VERDICT_KEEP) || (verdict == VERDICT_BIND) ||
			(verdict == VERDICT_SWITCH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_q      <= 1'b0;
			bound_id_q   <= '0;
			bound_str_q  <= '0;
			bound_ms_q   <= '0;
			rival_id_q   <= '0;
			rival_hits_q <= '0;
		end else if (advance) begin
			if (take) begin
				bound_q      <= 1'b1;
				bound_id_q   <= id_s1;
				bound_str_q  <= str_s1;
				bound_ms_q   <= time_s1;
				rival_id_q   <= '0;
				rival_hits_q <= '0;
			end else if (verdict == VERDICT_REFUSED) begin
				if (discovery) begin
					rival_id_q   <= '0;
					rival_hits_q <= '0;
				end else begin
					rival_id_q   <= id_s1;
					rival_hits_q <= hits_next;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_verdict_q  <= verdict;
			out_accepted_q <= take;
			out_shown_q    <= take ? id_s1 : bound_id_q;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.verdict  = out_verdict_q;
	assign result.accepted = out_accepted_q;
	assign result.shown_id = out_shown_q;

`ifndef SYNTH
	a_bound_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(bound_q))
		else $error("binding dropped");

	a_rival_needs_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(rival_hits_q != '0) |-> bound_q)
		else $error("challenger counted with nothing bound");

	a_accept_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_accepted_q == ((out_verdict_q == VERDICT_KEEP) ||
			(out_verdict_q == VERDICT_BIND) || (out_verdict_q == VERDICT_SWITCH))))
		else $error("accepted flag disagrees with verdict");

	a_accept_updates_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && take) |=> (bound_q && (bound_id_q == out_shown_q)))
		else $error("bound id not taken from accepted beacon");

	a_refuse_needs_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (verdict == VERDICT_REFUSED)) |-> bound_q)
		else $error("challenger refused with nothing bound");
`endif

endmodule
